// ===== design/kmi_pkg.sv =====
// ----------------------------------------------------------------------------
// kmi_pkg
// Shared types and constants for the k-means iteration block.
// ----------------------------------------------------------------------------
package kmi_pkg;

	localparam int MaxPoints  = 16384;
	localparam int MaxCenters = 64;
	localparam int CoordBits  = 16;

	localparam logic [1:0] REQ_LOAD_POINT  = 2'd0;
	localparam logic [1:0] REQ_LOAD_CENTER = 2'd1;
	localparam logic [1:0] REQ_RUN         = 2'd2;
	localparam logic [1:0] REQ_NONE        = 2'd3;

	localparam logic [0:0] REG_POINT_COUNT  = 1'b0;
	localparam logic [0:0] REG_CENTER_COUNT = 1'b1;

	// Divider request and reply between the sequencer and the divider.
	typedef struct packed {
		logic        go;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} kmi_div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} kmi_div_rsp_t;

endpackage

// ===== design/kmi_div.sv =====
// ----------------------------------------------------------------------------
// kmi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmi_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kmi_pkg::kmi_div_req_t req,
	output kmi_pkg::kmi_div_rsp_t rsp
);
	import kmi_pkg::*;

	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;

	// Shift the next dividend bit into the partial remainder.
	assign trial = {rem_q, quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one restoring step per cycle.
	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 17'(trial - {1'b0, den_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== design/kmeans_manhattan_iteration.sv =====
// ----------------------------------------------------------------------------
// kmeans_manhattan_iteration
// One k-means iteration with Manhattan distance over stored 2-D points.
// ----------------------------------------------------------------------------
// Usage: an item is a transfer with start high while busy is low. A load
// of a point or a center writes its memory; busy stays low, so loads may
// follow each other in every cycle. A run request raises busy, clears
// every accumulator entry, then walks every point in use against every
// center in use, one distance per cycle from the center memory read port.
// Then each center in use with members takes two divisions, x then y, and
// an empty center keeps its coordinates. Each result is shown for one
// cycle with strobe high, in index order; last marks the final one, with
// converged set when no center moved. busy falls in the cycle that shows
// the last result. The receiver cannot stall. Reset clears control state
// and sets the counts to their maximum; the memories hold no defined data
// until loaded. Configuration (point_count at 0, center_count at 4) must be
// written while busy is low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module kmeans_manhattan_iteration #(
	parameter int MAX_POINTS  = kmi_pkg::MaxPoints,
	parameter int MAX_CENTERS = kmi_pkg::MaxCenters,
	parameter int COORD_BITS  = kmi_pkg::CoordBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [13:0] item_index,
	input  logic [15:0] x_coord,
	input  logic [15:0] y_coord,
	output logic        strobe,
	output logic [5:0]  center_index,
	output logic [15:0] center_x,
	output logic [15:0] center_y,
	output logic        converged,
	output logic        last
);
	import kmi_pkg::*;

	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	// Sums hold up to 2^15 - 1 members of full-range coordinates.
	localparam int SW = COORD_BITS + 15;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_CLR   = 8'b00000010,
		ST_PT    = 8'b00000100,
		ST_SCAN  = 8'b00001000,
		ST_ACC   = 8'b00010000,
		ST_DIVX  = 8'b00100000,
		ST_DIVY  = 8'b01000000,
		ST_EMIT  = 8'b10000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [14:0] pcnt_q;
	logic [6:0]  ccnt_q;
	logic [16:0] np;
	logic [6:0]  nc;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= 15'd16384;
			ccnt_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_POINT_COUNT) pcnt_q <= pwdata[14:0];
			else ccnt_q <= pwdata[6:0];
		end
	end
	assign prdata = (paddr[2] == REG_POINT_COUNT) ? {17'd0, pcnt_q} : {25'd0, ccnt_q};

	// Counts in use, saturated; a center count of zero counts as one.
	always_comb begin
		np = ({2'd0, pcnt_q} > 17'(MAX_POINTS)) ? 17'(MAX_POINTS) : {2'd0, pcnt_q};
		if (ccnt_q == 7'd0) nc = 7'd1;
		else if (ccnt_q > 7'(MAX_CENTERS)) nc = 7'(MAX_CENTERS);
		else nc = ccnt_q;
	end

	logic acc;
	assign acc = start && !busy;

	// Memories.
	logic [COORD_BITS-1:0] ptx_mem [MAX_POINTS];
	logic [COORD_BITS-1:0] pty_mem [MAX_POINTS];
	logic [COORD_BITS-1:0] cx_mem  [MAX_CENTERS];
	logic [COORD_BITS-1:0] cy_mem  [MAX_CENTERS];
	logic [SW-1:0]         sx_mem  [MAX_CENTERS];
	logic [SW-1:0]         sy_mem  [MAX_CENTERS];
	logic [14:0]           mc_mem  [MAX_CENTERS];

	logic [16:0]           pi_q;
	logic [6:0]            ci_q;
	logic [COORD_BITS-1:0] px_q, py_q, crx_q, cry_q;
	logic [SW-1:0]         srx_q, sry_q;
	logic [14:0]           mcr_q;
	logic [17:0]           bd_q;
	logic [CW-1:0]         best_q;
	logic                  cv_s1;
	logic                  cv_s2;
	logic [CW-1:0]         cv_idx_s1;
	logic                  same_q;
	logic [COORD_BITS-1:0] nx_q;

	logic [CW-1:0] crd_addr;
	logic [CW-1:0] srd_addr;
	logic          c_wr, s_wr;
	logic [CW-1:0] c_wa, s_wa;
	logic [COORD_BITS-1:0] c_wx, c_wy;
	logic [SW-1:0] s_wx, s_wy;
	logic [14:0] s_wc;

	// Point memory: loads write, the run reads one point at a time.
	always_ff @(posedge clk) begin
		if (acc && req_type == REQ_LOAD_POINT && {3'd0, item_index} < np) begin
			ptx_mem[PW'(item_index)] <= x_coord[COORD_BITS-1:0];
			pty_mem[PW'(item_index)] <= y_coord[COORD_BITS-1:0];
		end
		px_q <= ptx_mem[pi_q[PW-1:0]];
		py_q <= pty_mem[pi_q[PW-1:0]];
	end

	// Center memory.
	always_ff @(posedge clk) begin
		if (c_wr) begin
			cx_mem[c_wa] <= c_wx;
			cy_mem[c_wa] <= c_wy;
		end
		crx_q <= cx_mem[crd_addr];
		cry_q <= cy_mem[crd_addr];
	end

	// Accumulator memory.
	always_ff @(posedge clk) begin
		if (s_wr) begin
			sx_mem[s_wa] <= s_wx;
			sy_mem[s_wa] <= s_wy;
			mc_mem[s_wa] <= s_wc;
		end
		srx_q <= sx_mem[srd_addr];
		sry_q <= sy_mem[srd_addr];
		mcr_q <= mc_mem[srd_addr];
	end

	// Distance of the point to the center read last cycle.
	logic [COORD_BITS:0] man_dist;
	logic [COORD_BITS-1:0] ddx, ddy;
	always_comb begin
		ddx  = (px_q > crx_q) ? px_q - crx_q : crx_q - px_q;
		ddy  = (py_q > cry_q) ? py_q - cry_q : cry_q - py_q;
		man_dist = {1'b0, ddx} + {1'b0, ddy};
	end

	kmi_div_req_t dreq;
	kmi_div_rsp_t drsp;
	kmi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [COORD_BITS-1:0] mean;
	assign mean = drsp.quotient[COORD_BITS-1:0];

	// Memory addresses and writes.
	always_comb begin
		crd_addr = cv_idx_s1;
		srd_addr = best_q;
		c_wr = 1'b0;
		c_wa = item_index[CW-1:0];
		c_wx = x_coord[COORD_BITS-1:0];
		c_wy = y_coord[COORD_BITS-1:0];
		s_wr = 1'b0;
		s_wa = ci_q[CW-1:0];
		s_wx = '0;
		s_wy = '0;
		s_wc = '0;
		dreq.go = 1'b0;
		dreq.dividend = {{(32-SW){1'b0}}, srx_q};
		dreq.divisor  = {2'd0, mcr_q};
		case (state_q)
			ST_IDLE: begin
				c_wr = acc && req_type == REQ_LOAD_CENTER && {3'd0, item_index} < {10'd0, nc};
			end
			ST_CLR: s_wr = 1'b1;
			ST_PT: crd_addr = '0;
			ST_SCAN: crd_addr = ci_q[CW-1:0];
			ST_ACC: begin
				s_wr = 1'b1;
				s_wa = best_q;
				s_wx = SW'(srx_q + {{(SW-COORD_BITS){1'b0}}, px_q});
				s_wy = SW'(sry_q + {{(SW-COORD_BITS){1'b0}}, py_q});
				s_wc = mcr_q + 15'd1;
			end
			ST_DIVX: begin
				srd_addr = ci_q[CW-1:0];
				crd_addr = ci_q[CW-1:0];
				// The y division starts as soon as the x quotient is out.
				dreq.go  = (cv_s2 && mcr_q != 15'd0) || drsp.done;
				if (drsp.done) dreq.dividend = {{(32-SW){1'b0}}, sry_q};
			end
			ST_DIVY: begin
				srd_addr = ci_q[CW-1:0];
				crd_addr = ci_q[CW-1:0];
			end
			ST_EMIT: begin
				crd_addr = ci_q[CW-1:0];
				c_wr = !cv_s1;
				c_wa = ci_q[CW-1:0];
				c_wx = nx_q;
				c_wy = mean;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pi_q         <= '0;
			ci_q         <= '0;
			cv_s1        <= 1'b0;
			cv_s2        <= 1'b0;
			cv_idx_s1    <= '0;
			strobe       <= 1'b0;
			last         <= 1'b0;
			converged    <= 1'b0;
			center_index <= '0;
			center_x     <= '0;
			center_y     <= '0;
			nx_q         <= '0;
			same_q       <= 1'b1;
			best_q       <= '0;
			bd_q         <= '0;
		end else begin
			strobe <= 1'b0;
			cv_s1  <= 1'b0;
			cv_s2  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc && req_type == REQ_RUN) begin
						state_q <= ST_CLR;
						ci_q    <= '0;
						pi_q    <= '0;
						same_q  <= 1'b1;
					end
				end
				ST_CLR: begin
					ci_q <= ci_q + 7'd1;
					if (ci_q == 7'(MAX_CENTERS - 1)) begin
						ci_q <= '0;
						state_q <= (np == 17'd0) ? ST_DIVX : ST_PT;
						cv_s1 <= (np == 17'd0);
					end
				end
				ST_PT: begin
					// Point data is ready next cycle; center 0 is read now.
					ci_q    <= 7'd1;
					bd_q    <= '1;
					best_q  <= '0;
					cv_s1   <= 1'b1;
					cv_idx_s1 <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cv_s1 && {1'b0, man_dist} < bd_q) begin
						bd_q   <= {1'b0, man_dist};
						best_q <= cv_idx_s1;
					end
					if (ci_q < nc) begin
						cv_s1     <= 1'b1;
						cv_idx_s1 <= ci_q[CW-1:0];
						ci_q      <= ci_q + 7'd1;
					end else if (!cv_s1) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					// Sum read settled last cycle at best_q; write back now.
					pi_q <= pi_q + 17'd1;
					if (pi_q + 17'd1 == np) begin
						state_q <= ST_DIVX;
						ci_q <= '0;
						cv_s1 <= 1'b1;
					end else begin
						state_q <= ST_PT;
					end
				end
				ST_DIVX: begin
					// The address goes out while cv_s1 is high; sums, count
					// and center are valid while cv_s2 is high.
					if (cv_s1) begin
						cv_s2 <= 1'b1;
					end else if (cv_s2) begin
						if (mcr_q == 15'd0) begin
							nx_q <= crx_q;
							state_q <= ST_EMIT;
							cv_s1 <= 1'b1;
						end
					end else if (drsp.done) begin
						nx_q <= mean;
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (drsp.done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// Empty center: cv_s1 marks the value kept.
					strobe       <= 1'b1;
					center_index <= 6'(ci_q);
					center_x     <= 16'(nx_q);
					center_y     <= cv_s1 ? 16'(cry_q) : 16'(mean);
					last         <= (ci_q + 7'd1 == nc);
					converged    <= (ci_q + 7'd1 == nc) && same_q &&
						nx_q == crx_q && (cv_s1 ? 1'b1 : mean == cry_q);
					if (nx_q != crx_q || (!cv_s1 && mean != cry_q)) same_q <= 1'b0;
					ci_q <= ci_q + 7'd1;
					if (ci_q + 7'd1 == nc) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIVX;
						cv_s1 <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== design/kmi_checker.sv =====
// ----------------------------------------------------------------------------
// kmi_checker
// Port-level checks on the k-means iteration block.
// ----------------------------------------------------------------------------
module kmi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last,
	input logic converged
);
	// A result appears only during a run.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result outside a run");

	// Converged is only flagged on the last result.
	a_conv_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && converged) |-> last) else $error("converged without last");

	// Busy is already low while the last result is shown.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy) else $error("busy after last result");

	// Last only rises together with its strobe.
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(last) |-> strobe) else $error("last without strobe");

	// A run only begins on a request.
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without a request");
endmodule

bind kmeans_manhattan_iteration kmi_checker u_kmi_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .last(last), .converged(converged)
);

// ===== sim/kmeans_manhattan_iteration_tb.sv =====
// ----------------------------------------------------------------------------
// kmeans_manhattan_iteration_tb
// Self-checking regression for the Manhattan k-means iteration block.
// Points and centers are loaded through the command port, and runs are
// issued under several point and center counts, zero points and all 64 centers among them.
// A scoreboard keeps its own copy of the stores and works out each run's
// center results, which are then compared field by field as they strobe out.
// ----------------------------------------------------------------------------
module kmeans_manhattan_iteration_tb;
	import kmi_pkg::*;

	localparam int CycleLimit = 12000000;
	localparam int ItemTarget = 380;
	localparam int QuietTail  = 50;

	typedef struct packed {
		logic [5:0]  index;
		logic [15:0] x;
		logic [15:0] y;
		logic        conv;
		logic        fin;
	} center_result_t;

	// Scoreboard: shadow stores, the center update and the result checks.
	class kmeans_scoreboard;
		logic [15:0]    pt_x[MaxPoints];
		logic [15:0]    pt_y[MaxPoints];
		logic [15:0]    ctr_x[MaxCenters];
		logic [15:0]    ctr_y[MaxCenters];
		int unsigned    point_reg = 16384;
		int unsigned    center_reg = 64;
		center_result_t pending[$];
		int             mismatches;
		int             results_seen;
		int             runs_seen;

		function int unsigned used_points();
			return (point_reg > MaxPoints) ? MaxPoints : point_reg;
		endfunction

		function int unsigned used_centers();
			if (center_reg == 0)
				return 1;
			return (center_reg > MaxCenters) ? MaxCenters : center_reg;
		endfunction

		function void set_register(logic [0:0] addr, logic [31:0] value);
			if (addr == REG_POINT_COUNT)
				point_reg = value & 32'h7FFF;
			else
				center_reg = value & 32'h7F;
		endfunction

		// Record an accepted request; a run yields one result per center.
		function void note_request(logic [1:0] req, logic [13:0] idx,
				logic [15:0] x, logic [15:0] y);
			longint unsigned sx[MaxCenters];
			longint unsigned sy[MaxCenters];
			int unsigned     members[MaxCenters];
			int unsigned     np;
			int unsigned     nc;
			int unsigned     best;
			int unsigned     best_d;
			int unsigned     d;
			logic [15:0]     nx;
			logic [15:0]     ny;
			bit              still;
			center_result_t  r;
			np = used_points();
			nc = used_centers();
			if (req == REQ_LOAD_POINT) begin
				if (idx < np) begin
					pt_x[idx] = x;
					pt_y[idx] = y;
				end
				return;
			end
			if (req == REQ_LOAD_CENTER) begin
				if (idx < nc) begin
					ctr_x[idx] = x;
					ctr_y[idx] = y;
				end
				return;
			end
			if (req != REQ_RUN)
				return;
			runs_seen++;
			for (int c = 0; c < MaxCenters; c++) begin
				sx[c] = 0;
				sy[c] = 0;
				members[c] = 0;
			end
			// Nearest center by |dx|+|dy|; strict compare keeps the lowest index.
			for (int i = 0; i < np; i++) begin
				best = 0;
				best_d = 0;
				for (int c = 0; c < nc; c++) begin
					d = ((pt_x[i] > ctr_x[c]) ? pt_x[i] - ctr_x[c] : ctr_x[c] - pt_x[i])
						+ ((pt_y[i] > ctr_y[c]) ? pt_y[i] - ctr_y[c] : ctr_y[c] - pt_y[i]);
					if (c == 0 || d < best_d) begin
						best_d = d;
						best = c;
					end
				end
				sx[best] += pt_x[i];
				sy[best] += pt_y[i];
				members[best]++;
			end
			// Floored means; an empty cluster keeps its center.
			still = 1'b1;
			for (int c = 0; c < nc; c++) begin
				nx = ctr_x[c];
				ny = ctr_y[c];
				if (members[c] != 0) begin
					nx = 16'(sx[c] / members[c]);
					ny = 16'(sy[c] / members[c]);
				end
				if (nx != ctr_x[c] || ny != ctr_y[c])
					still = 1'b0;
				ctr_x[c] = nx;
				ctr_y[c] = ny;
			end
			for (int c = 0; c < nc; c++) begin
				r.index = 6'(c);
				r.x = ctr_x[c];
				r.y = ctr_y[c];
				r.fin = (c + 1 == nc);
				r.conv = r.fin && still;
				pending.push_back(r);
			end
		endfunction

		// Compare one strobed result with the oldest expectation.
		function void check_result(center_result_t got);
			center_result_t exp_r;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected center result: idx=%0d x=%0d y=%0d conv=%0b last=%0b",
						got.index, got.x, got.y, got.conv, got.fin);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("center mismatch: exp idx=%0d x=%0d y=%0d conv=%0b last=%0b, %s",
						exp_r.index, exp_r.x, exp_r.y, exp_r.conv, exp_r.fin,
						$sformatf("got idx=%0d x=%0d y=%0d conv=%0b last=%0b",
						got.index, got.x, got.y, got.conv, got.fin));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:2]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [13:0] item_index;
	logic [15:0] x_coord;
	logic [15:0] y_coord;
	logic        strobe;
	logic [5:0]  center_index;
	logic [15:0] center_x;
	logic [15:0] center_y;
	logic        converged;
	logic        last;

	kmeans_scoreboard sb;
	bit               point_loaded[MaxPoints];
	bit               center_loaded[MaxCenters];
	int               items_sent;
	int               cycle_count;
	bit               allow_gaps;

	kmeans_manhattan_iteration u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.item_index   (item_index),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.strobe       (strobe),
		.center_index (center_index),
		.center_x     (center_x),
		.center_y     (center_y),
		.converged    (converged),
		.last         (last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("kmeans_manhattan_iteration regression: fail");
			$finish;
		end
	end

	// Every strobed result is a transfer the receiver must take.
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result({center_index, center_x, center_y, converged, last});
	end

	// Issue one request, with an optional idle burst before it.
	task automatic send_item(logic [1:0] req, logic [13:0] idx,
			logic [15:0] x, logic [15:0] y);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		item_index <= idx;
		x_coord <= x;
		y_coord <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (req == REQ_LOAD_POINT && idx < sb.used_points())
			point_loaded[idx] = 1'b1;
		if (req == REQ_LOAD_CENTER && idx < sb.used_centers())
			center_loaded[idx] = 1'b1;
		sb.note_request(req, idx, x, y);
		items_sent++;
	endtask

	// Drain all outstanding results, then let the block settle.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_reg(logic [0:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(addr, value);
	endtask

	// Coordinates: full range half the time, else near a few shared spots.
	function automatic logic [15:0] rand_coord();
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 3) * 16000 + $urandom_range(0, 40));
	endfunction

	// Every point and center a run would read must have been loaded.
	function automatic bit stores_ready();
		for (int i = 0; i < sb.used_points(); i++)
			if (!point_loaded[i])
				return 1'b0;
		for (int c = 0; c < sb.used_centers(); c++)
			if (!center_loaded[c])
				return 1'b0;
		return 1'b1;
	endfunction

	// One random phase under the current counts.
	task automatic random_phase(int budget);
		int          sent;
		int          pick;
		int          np;
		int          nc;
		logic [13:0] idx;
		sent = 0;
		np = sb.used_points();
		nc = sb.used_centers();
		while (sent < budget) begin
			if (items_sent > ItemTarget - QuietTail)
				allow_gaps = 1'b0;
			pick = $urandom_range(0, 99);
			if (!stores_ready()) begin
				// Fill the stores in use before any run.
				idx = 0;
				for (int i = np - 1; i >= 0; i--)
					if (!point_loaded[i])
						idx = 14'(i);
				if (point_loaded[idx] || np == 0) begin
					for (int c = nc - 1; c >= 0; c--)
						if (!center_loaded[c])
							idx = 14'(c);
					send_item(REQ_LOAD_CENTER, idx, rand_coord(), rand_coord());
				end else begin
					send_item(REQ_LOAD_POINT, idx, rand_coord(), rand_coord());
				end
			end else if (pick < 30) begin
				send_item(REQ_RUN, 14'($urandom_range(0, 16383)), 16'($urandom),
					16'($urandom));
			end else if (pick < 60 && np > 0) begin
				send_item(REQ_LOAD_POINT, 14'($urandom_range(0, np - 1)),
					rand_coord(), rand_coord());
			end else if (pick < 85) begin
				send_item(REQ_LOAD_CENTER, 14'($urandom_range(0, nc - 1)),
					rand_coord(), rand_coord());
			end else if (pick < 90) begin
				send_item(REQ_NONE, 14'($urandom_range(0, 16383)), 16'($urandom),
					16'($urandom));
			end else if (pick < 95) begin
				send_item(REQ_LOAD_POINT, 14'($urandom_range(np, 16383)),
					16'($urandom), 16'($urandom));
			end else begin
				send_item(REQ_LOAD_CENTER, 14'($urandom_range(nc, 16383)),
					16'($urandom), 16'($urandom));
			end
			sent++;
		end
	endtask

	// Stimulus.
	initial begin
		int pc;
		int cc;
		int phase;
		sb = new();
		cycle_count = 0;
		items_sent = 0;
		allow_gaps = 1'b1;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		req_type = '0;
		item_index = '0;
		x_coord = '0;
		y_coord = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Point count beyond range saturates, a zero center count counts as one; loads only, at the index extremes.
		write_reg(REG_POINT_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_CENTER_COUNT, 32'hFFFF_FF80);
		send_item(REQ_LOAD_POINT, 14'h3FFF, 16'hFFFF, 16'hFFFF);
		send_item(REQ_LOAD_POINT, 14'h0000, 16'h0000, 16'h0000);
		send_item(REQ_LOAD_CENTER, 14'd0, 16'h1234, 16'hABCD);
		send_item(REQ_LOAD_CENTER, 14'd1, 16'h5555, 16'hAAAA);
		send_item(REQ_NONE, 14'h3FFF, 16'hFFFF, 16'hFFFF);
		wait_idle();

		// Small set with a distance tie and coordinates at the top of range.
		write_reg(REG_POINT_COUNT, 32'd4);
		write_reg(REG_CENTER_COUNT, 32'd3);
		send_item(REQ_LOAD_CENTER, 14'd0, 16'd0, 16'd0);
		send_item(REQ_LOAD_CENTER, 14'd1, 16'd10, 16'd0);
		send_item(REQ_LOAD_CENTER, 14'd2, 16'hFFFF, 16'hFFFF);
		send_item(REQ_LOAD_CENTER, 14'd3, 16'd7, 16'd7);
		send_item(REQ_LOAD_POINT, 14'd0, 16'd5, 16'd0);
		send_item(REQ_LOAD_POINT, 14'd1, 16'hFFFF, 16'hFFFF);
		send_item(REQ_LOAD_POINT, 14'd2, 16'hFFFE, 16'hFFFF);
		send_item(REQ_LOAD_POINT, 14'd3, 16'd10, 16'd0);
		send_item(REQ_LOAD_POINT, 14'd4, 16'd9, 16'd9);
		send_item(REQ_RUN, 14'd0, 16'd0, 16'd0);
		send_item(REQ_RUN, 14'h2AAA, 16'h5555, 16'hAAAA);
		wait_idle();

		// No points in use: every center stays and the run converges.
		write_reg(REG_POINT_COUNT, 32'd0);
		write_reg(REG_CENTER_COUNT, 32'd2);
		send_item(REQ_RUN, 14'd0, 16'd0, 16'd0);
		wait_idle();

		// Random phases; the first two hold the center count at its top.
		phase = 0;
		while (items_sent < ItemTarget) begin
			pc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
			case ($urandom_range(0, 9))
				0, 1: cc = $urandom_range(9, 64);
				2: cc = $urandom_range(65, 127);
				3: cc = 0;
				default: cc = $urandom_range(1, 8);
			endcase
			if (phase == 0)
				cc = 64;
			if (phase == 1)
				cc = 127;
			write_reg(REG_POINT_COUNT, ($urandom & 32'hFFFF_8000) | pc);
			write_reg(REG_CENTER_COUNT, ($urandom & 32'hFFFF_FF80) | cc);
			random_phase($urandom_range(25, 45));
			wait_idle();
			phase++;
		end

		repeat (20) @(posedge clk);
		$display("covered %0d requests in %0d phases: %0d runs, %0d center results",
			items_sent, phase + 3, sb.runs_seen, sb.results_seen);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("kmeans_manhattan_iteration regression: pass");
		end else begin
			$display("kmeans_manhattan_iteration regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/kmi_pkg.sv
design/kmi_div.sv
design/kmeans_manhattan_iteration.sv
design/kmi_checker.sv
sim/kmeans_manhattan_iteration_tb.sv
